FILE: hw/rtl/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared property shorthands for the console RTL. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Condition must never hold
`define TCW_ASSERT_NEVER(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/txtcon_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Shared types, opcodes, character codes and default geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package txtcon_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths of the stream payload
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int CELL_W   = 16;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Cell contents written by clear and by blanking
    localparam logic [CELL_W-1:0] CELL_CLEAR = {8'h00, CH_SPACE};
    localparam logic [CELL_W-1:0] CELL_BLANK = 16'h0000;

    // Request opcodes; code three is a no-op
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_COPY,
        S_DRAIN,
        S_BLANK,
        S_PUT,
        S_READ,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic idx_clr;
        logic home;
        logic clr_step;
        logic copy_rd;
        logic blank_step;
        logic scroll_done;
        logic put_exec;
        logic rd_issue;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic is_bs;
        logic pending;
        logic idx_full;
        logic copy_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/txtcon_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences clear sweeps, scroll copies, puts and reads over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module txtcon_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire txtcon_pkg::dp_stat_t stat,
    output txtcon_pkg::dp_cmd_t      cmd
);
    import txtcon_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (stat.idx_full)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_PUT:
                    begin
                        if (!stat.is_bs && stat.pending)
                        begin
                            state_next = S_COPY;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    OP_READ:  state_next = S_READ;
                    OP_CLEAR: state_next = S_CLEAR;
                    default:  state_next = S_DONE;
                endcase
            end
            S_CLEAR:
            begin
                if (stat.idx_full)
                begin
                    state_next = S_DONE;
                end
            end
            S_COPY:
            begin
                if (stat.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_BLANK;
            S_BLANK:
            begin
                if (stat.idx_full)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:  state_next = S_DONE;
            S_READ: state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_PUT:
                    begin
                        cmd.idx_clr = !stat.is_bs && stat.pending;
                    end
                    OP_CLEAR:
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.home    = 1'b1;
                    end
                    default:
                    begin
                        cmd.idx_clr = 1'b0;
                    end
                endcase
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_COPY:
            begin
                cmd.copy_rd = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.copy_rd = 1'b0;
            end
            S_BLANK:
            begin
                cmd.blank_step  = 1'b1;
                cmd.scroll_done = stat.idx_full;
            end
            S_PUT:
            begin
                cmd.put_exec = 1'b1;
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/txtcon_dp.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Request registers, cursor, cell memory with one write and one read port,
// sweep index for clear and scroll, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_defines.svh"

module txtcon_dp #(
    parameter int COLUMNS = txtcon_pkg::DEF_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEF_ROWS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire txtcon_pkg::dp_cmd_t                 cmd,
    output txtcon_pkg::dp_stat_t                     stat,
    input  wire logic [txtcon_pkg::OP_W-1:0]         s_tuser,
    input  wire logic [txtcon_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [txtcon_pkg::M_DATA_W-1:0]          m_tdata
);
    import txtcon_pkg::*;

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int IDX_W  = $clog2(TOTAL + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] ROW_PEND = ROW_W'(ROWS);

    // Request registers
    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [RROW_W-1:0] rrow_reg;
    logic [RCOL_W-1:0] rcol_reg;

    // Cursor and sweep state
    logic [COL_W-1:0]  cur_x_reg;
    logic [COL_W-1:0]  cur_x_next;
    logic [ROW_W-1:0]  cur_y_reg;
    logic [ROW_W-1:0]  cur_y_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              scrolled_reg;
    logic              scrolled_next;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_idx_reg;

    // Cell memory
    logic [CELL_W-1:0] mem [TOTAL];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    // Result register
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [CELL_W-1:0] out_cell_reg;
    logic [OCOL_W-1:0] out_col_reg;
    logic [OROW_W-1:0] out_row_reg;
    logic              out_scr_reg;

    // Put decode
    logic [COL_W-1:0]  put_nx;
    logic [ROW_W-1:0]  put_ny;
    logic [COL_W-1:0]  put_wx;
    logic [ROW_W-1:0]  put_wy;
    logic              put_we;
    logic [CELL_W-1:0] put_wd;
    logic [15:0]       put_lin;
    logic [15:0]       rd_lin;
    logic [IDX_W-1:0]  copy_src;
    logic              range_ok;
    logic [15:0]       col_wide;
    logic [15:0]       row_wide;

    // Capture a request
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= s_tuser;
            ch_reg   <= s_tdata[7:0];
            attr_reg <= s_tdata[15:8];
            rrow_reg <= s_tdata[20:16];
            rcol_reg <= s_tdata[27:21];
        end
    end

    // Decode a put: backspace, newline or any other byte
    always_comb
    begin
        put_nx = cur_x_reg;
        put_ny = cur_y_reg;
        put_wx = cur_x_reg;
        put_wy = cur_y_reg;
        put_we = 1'b0;
        put_wd = CELL_BLANK;
        if (ch_reg == CH_BACKSPACE)
        begin
            if (!(cur_x_reg == '0 && cur_y_reg == '0))
            begin
                if (cur_x_reg == '0)
                begin
                    put_nx = COL_LAST;
                    put_ny = cur_y_reg - ROW_W'(1);
                end
                else
                begin
                    put_nx = cur_x_reg - COL_W'(1);
                end
                put_wx = put_nx;
                put_wy = put_ny;
                put_we = (put_ny < ROW_PEND);
            end
        end
        else if (ch_reg == CH_NEWLINE)
        begin
            put_nx = '0;
            put_ny = cur_y_reg + ROW_W'(1);
        end
        else
        begin
            put_we = (cur_y_reg < ROW_PEND);
            put_wd = {attr_reg, ch_reg};
            if (cur_x_reg >= COL_LAST)
            begin
                put_nx = '0;
                put_ny = cur_y_reg + ROW_W'(1);
            end
            else
            begin
                put_nx = cur_x_reg + COL_W'(1);
            end
        end
    end

    // Linear cell addresses
    assign put_lin  = 16'(put_wy) * 16'(COLUMNS) + 16'(put_wx);
    assign rd_lin   = 16'(rrow_reg) * 16'(COLUMNS) + 16'(rcol_reg);
    assign copy_src = idx_reg + IDX_W'(COLUMNS);
    assign range_ok = (32'(rrow_reg) < 32'(ROWS)) && (32'(rcol_reg) < 32'(COLUMNS));

    // Select the single memory write of this cycle
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg[ADDR_W-1:0];
        mem_wd = CELL_BLANK;
        priority if (cmd.clr_step)
        begin
            mem_we = 1'b1;
            mem_wd = CELL_CLEAR;
        end
        else if (wr_pend_reg)
        begin
            mem_we = 1'b1;
            mem_wa = wr_idx_reg;
            mem_wd = rd_data_reg;
        end
        else if (cmd.blank_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.put_exec)
        begin
            mem_we = put_we;
            mem_wa = put_lin[ADDR_W-1:0];
            mem_wd = put_wd;
        end
    end

    // Read port: scroll source row or requested cell
    assign mem_re = cmd.copy_rd || (cmd.rd_issue && range_ok);
    assign mem_ra = cmd.copy_rd ? copy_src[ADDR_W-1:0] : rd_lin[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Delay the copy write to the cycle after its read
    always_ff @(posedge clk)
    begin
        wr_idx_reg <= idx_reg[ADDR_W-1:0];
    end

    // Advance the sweep index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.clr_step || cmd.copy_rd || cmd.blank_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Move the cursor
    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        scrolled_next = scrolled_reg;
        if (cmd.load_in)
        begin
            scrolled_next = 1'b0;
        end
        if (cmd.home)
        begin
            cur_x_next = '0;
            cur_y_next = '0;
        end
        else if (cmd.scroll_done)
        begin
            cur_y_next    = ROW_LAST;
            scrolled_next = 1'b1;
        end
        else if (cmd.put_exec)
        begin
            cur_x_next = put_nx;
            cur_y_next = put_ny;
        end
    end

    // Hold or drop the result
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            idx_reg      <= '0;
            scrolled_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            idx_reg      <= idx_next;
            scrolled_reg <= scrolled_next;
            wr_pend_reg  <= cmd.copy_rd;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload
    assign col_wide = 16'(cur_x_reg);
    assign row_wide = 16'(cur_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cell_reg <= (op_reg == OP_READ && range_ok) ? rd_data_reg : '0;
            out_col_reg  <= col_wide[OCOL_W-1:0];
            out_row_reg  <= row_wide[OROW_W-1:0];
            out_scr_reg  <= scrolled_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_scr_reg, out_row_reg, out_col_reg, out_cell_reg};

    // Status
    assign stat.op        = op_t'(op_reg);
    assign stat.is_bs     = (ch_reg == CH_BACKSPACE);
    assign stat.pending   = (cur_y_reg == ROW_PEND);
    assign stat.idx_full  = (idx_reg == IDX_W'(TOTAL - 1));
    assign stat.copy_last = (idx_reg == IDX_W'(COPY_N - 1));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    `TCW_ASSERT_NEVER(a_col_range, cur_x_reg > COL_LAST, "cursor column beyond last column")
    `TCW_ASSERT_NEVER(a_row_range, cur_y_reg > ROW_PEND, "cursor row beyond pending row")
    `TCW_ASSERT_NEVER(a_wr_clash, cmd.clr_step && wr_pend_reg, "clear step during copy write")
    `TCW_ASSERT_IMPLY(a_out_free, cmd.out_load, !m_tvalid_reg || m_tready, "result overwritten")
    `TCW_ASSERT_NEXT(a_scroll_row, cmd.scroll_done, cur_y_reg == ROW_LAST && scrolled_reg, "scroll did not land on last row")

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Grid of 16-bit cells (color high byte, character low byte) with a cursor;
// put, read and clear requests, one result per request.
// ----------------------------------------------------------------------------
//  channel | dir | signals                      | contents
//  s_*     | in  | s_tvalid s_tready s_tdata    | request: opcode in s_tuser,
//          |     | s_tuser                      |   char, color, read row/col
//  m_*     | out | m_tvalid m_tready m_tdata    | result: cell, cursor, scroll
//
// Put and read are dispatched, executed, then loaded into the result register.
// A scrolling put first copies rows up one and blanks the last row, and clear
// sweeps every cell, both through the single write port of the cell memory.
// After reset a clearing pass over all ROWS*COLUMNS cells (2000 by default) runs
// before s_tready rises. One request is in work at a time; a pending result
// stalls only the final step of the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = txtcon_pkg::DEF_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEF_ROWS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [1:0] opcode
    input  wire logic [txtcon_pkg::OP_W-1:0]      s_tuser,
    // [7:0] char_code, [15:8] attr_color, [20:16] read_row, [27:21] read_col
    input  wire logic [txtcon_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] cell_value, [22:16] cursor_col, [27:23] cursor_row, [28] did_scroll
    output logic [txtcon_pkg::M_DATA_W-1:0]       m_tdata
);
    import txtcon_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    txtcon_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    txtcon_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, read, clear and no-op requests into the console stream port.
// Every accepted request is run through a behavioral model of the screen and
// cursor. Each returned result is checked field by field against the oldest
// expected one. A directed table covers reset contents, the backspace corners,
// newline, wrap, the lazy scroll and out-of-range reads. Random requests follow
// with bursty stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------

module testbench;

    import txtcon_pkg::*;

    // Geometry and run control
    localparam int COLUMNS       = DEF_COLUMNS;
    localparam int ROWS          = DEF_ROWS;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CALM_TAIL     = 60;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 64;
    localparam int LIMIT_CYCLES  = 6_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 26;

    // Unused opcode, handled as a no-op
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    // Result fields, lowest bit at the bottom of the struct
    typedef struct packed {
        logic              did_scroll;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
        logic [CELL_W-1:0] cell_val;
    } console_result_t;

    // One request with an optional hand-written expectation
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] color;
        logic [RROW_W-1:0] rr;
        logic [RCOL_W-1:0] rc;
        logic [5:0]        reps;
        logic              typed;
        console_result_t   want;
    } console_req_t;

    localparam console_result_t RES_ZERO  = '0;
    localparam console_result_t RES_SPACE = '{1'b0, 5'd0, 7'd0, CELL_CLEAR};

    // Directed requests: reset contents, corners of backspace, scroll, clear
    localparam console_req_t DIRECTED [0:DIR_ROWS-1] = '{
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd0,   6'd1,  1'b1, RES_SPACE},
        '{OP_PUT,   CH_BACKSPACE, 8'hFF, 5'd0,  7'd0,   6'd1,  1'b1, RES_ZERO},
        '{OP_READ,  8'hFF,        8'hFF, 5'd31, 7'd127, 6'd1,  1'b1, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd24, 7'd79,  6'd1,  1'b1, RES_SPACE},
        '{OP_NOP,   8'hFF,        8'hFF, 5'd31, 7'd127, 6'd1,  1'b1, RES_ZERO},
        '{OP_PUT,   8'h41,        8'h00, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   8'hFF,        8'hFF, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd1,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   CH_BACKSPACE, 8'h12, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd1,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   CH_NEWLINE,   8'h34, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   CH_BACKSPACE, 8'h00, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd79,  6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   CH_NEWLINE,   8'h00, 5'd0,  7'd0,   6'd25, 1'b0, RES_ZERO},
        '{OP_PUT,   CH_BACKSPACE, 8'h00, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   8'h7A,        8'h5A, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd24, 7'd79,  6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   8'h71,        8'h07, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd23, 7'd79,  6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   CH_NEWLINE,   8'h00, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   CH_NEWLINE,   8'h00, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_PUT,   8'h80,        8'h80, 5'd0,  7'd0,   6'd1,  1'b0, RES_ZERO},
        '{OP_CLEAR, 8'h00,        8'h00, 5'd0,  7'd0,   6'd1,  1'b1, RES_ZERO},
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd0,   6'd1,  1'b1, RES_SPACE},
        '{OP_READ,  8'h00,        8'h00, 5'd0,  7'd80,  6'd1,  1'b1, RES_ZERO}
    };

    // DUT ports, the driven inputs at known values from time zero
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Model state of the screen and cursor
    logic [CELL_W-1:0] screen [0:ROWS*COLUMNS-1];
    logic [OCOL_W-1:0] cur_col;
    logic [OROW_W-1:0] cur_row;

    // Request list, pending expectations, counters
    console_req_t    request_q [$];
    console_result_t expect_q [$];
    console_result_t got_res;
    console_result_t want_res;
    console_result_t pred_res;
    int              total_items  = 0;
    int              accepted     = 0;
    int              checked      = 0;
    int              fail_count   = 0;
    int              scroll_count = 0;
    int              read_count   = 0;
    int              clear_count  = 0;
    int              cycle_count  = 0;
    int              rx_left      = 0;
    bit              rx_stall     = 1'b0;
    int              hold_count   = 0;
    bit              hold_done    = 1'b0;

    text_console_writer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Fill the model grid with black spaces and home the cursor
    function automatic void clear_model();
        for (int i = 0; i < ROWS * COLUMNS; i++)
            screen[i] = CELL_CLEAR;
        cur_col = '0;
        cur_row = '0;
    endfunction

    // Drop writes that fall outside the grid
    function automatic void write_model_cell(logic [OCOL_W-1:0] col, logic [OROW_W-1:0] row,
                                             logic [CELL_W-1:0] value);
        if (col < COLUMNS && row < ROWS)
            screen[int'(row) * COLUMNS + int'(col)] = value;
    endfunction

    // Put one character at the cursor; return 1 when the screen scrolled
    function automatic logic put_model_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] color);
        logic scrolled = 1'b0;
        if (ch == CH_BACKSPACE)
        begin
            if (cur_col == 0 && cur_row == 0)
                return 1'b0;
            if (cur_col == 0)
            begin
                cur_row = cur_row - OROW_W'(1);
                cur_col = OCOL_W'(COLUMNS - 1);
            end
            else
            begin
                cur_col = cur_col - OCOL_W'(1);
            end
            write_model_cell(cur_col, cur_row, CELL_BLANK);
            return 1'b0;
        end
        // Run the pending scroll before anything else
        if (cur_row == ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = 0; i < COLUMNS; i++)
                screen[(ROWS - 1) * COLUMNS + i] = CELL_BLANK;
            cur_row  = OROW_W'(ROWS - 1);
            scrolled = 1'b1;
            scroll_count++;
        end
        if (ch == CH_NEWLINE)
        begin
            cur_row = cur_row + OROW_W'(1);
            cur_col = '0;
            return scrolled;
        end
        write_model_cell(cur_col, cur_row, {color, ch});
        if (cur_col >= COLUMNS - 1)
        begin
            cur_col = '0;
            cur_row = cur_row + OROW_W'(1);
        end
        else
        begin
            cur_col = cur_col + OCOL_W'(1);
        end
        return scrolled;
    endfunction

    // Advance the model by one request and return its result
    function automatic console_result_t predict_console(logic [OP_W-1:0] op,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic [ATTR_W-1:0] color,
                                                        logic [RROW_W-1:0] rr,
                                                        logic [RCOL_W-1:0] rc);
        console_result_t res = '0;
        case (op)
            OP_PUT:   res.did_scroll = put_model_char(ch, color);
            OP_READ:
            begin
                read_count++;
                if (rr < ROWS && rc < COLUMNS)
                    res.cell_val = screen[int'(rr) * COLUMNS + int'(rc)];
            end
            OP_CLEAR:
            begin
                clear_count++;
                clear_model();
            end
            default: ;
        endcase
        res.col = cur_col;
        res.row = cur_row;
        return res;
    endfunction

    // Append one request that is checked against the model
    function automatic void push_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                         logic [ATTR_W-1:0] color, logic [RROW_W-1:0] rr,
                                         logic [RCOL_W-1:0] rc);
        console_req_t r;
        r       = '0;
        r.op    = op;
        r.ch    = ch;
        r.color = color;
        r.rr    = rr;
        r.rc    = rc;
        r.reps  = 6'd1;
        request_q.push_back(r);
    endfunction

    // No idling in the tail and in every fourth stretch of requests
    function automatic bit quiet_phase(int n);
        return (n + CALM_TAIL >= total_items) || ((n / 60) % 4 == 3);
    endfunction

    // Predict each accepted request
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            pred_res = predict_console(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                       s_tdata[20:16], s_tdata[27:21]);
            if (request_q[accepted].typed)
                expect_q.push_back(request_q[accepted].want);
            else
                expect_q.push_back(pred_res);
            accepted++;
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = m_tdata[28:0];
            if (expect_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: cell %h col %0d row %0d scroll %0d",
                             got_res.cell_val, got_res.col, got_res.row, got_res.did_scroll);
            end
            else
            begin
                want_res = expect_q.pop_front();
                checked++;
                if (got_res.cell_val !== want_res.cell_val || got_res.col !== want_res.col ||
                    got_res.row !== want_res.row ||
                    got_res.did_scroll !== want_res.did_scroll)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result %0d: exp %h %0d %0d %0d, got %h %0d %0d %0d",
                                 checked, want_res.cell_val, want_res.col, want_res.row,
                                 want_res.did_scroll, got_res.cell_val, got_res.col,
                                 got_res.row, got_res.did_scroll);
                end
            end
        end
    end

    // Stall the result side in bursts, with one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && accepted >= HOLD_AT)
            begin
                if (hold_count < HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    hold_count++;
                end
                else
                begin
                    m_tready  <= 1'b1;
                    hold_done = 1'b1;
                end
            end
            else if (quiet_phase(accepted))
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_stall = ($urandom_range(0, 3) == 0);
                    rx_left  = rx_stall ? $urandom_range(1, 18) : $urandom_range(1, 30);
                end
                m_tready <= !rx_stall;
                rx_left--;
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Build the request list, reset, drive requests, then wrap up
    initial
    begin
        int           rand_items;
        int           kind;
        int           n;
        console_req_t r;

        clear_model();

        // Expand the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            r      = DIRECTED[i];
            r.reps = 6'd1;
            for (int k = 0; k < DIRECTED[i].reps; k++)
                request_q.push_back(r);
        end

        // Random traffic: text, newline runs that force scrolls, reads, noise
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            n    = 1;
            if (kind < 30)
            begin
                push_request(OP_PUT, 8'($urandom_range(0, 255)), 8'($urandom),
                             5'($urandom), 7'($urandom));
            end
            else if (kind < 45)
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    push_request(OP_PUT, CH_NEWLINE, 8'($urandom), 5'($urandom), 7'($urandom));
            end
            else if (kind < 53)
            begin
                push_request(OP_PUT, CH_BACKSPACE, 8'($urandom), 5'($urandom), 7'($urandom));
            end
            else if (kind < 76)
            begin
                push_request(OP_READ, 8'($urandom), 8'($urandom),
                             5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
            end
            else if (kind < 83)
            begin
                push_request(OP_READ, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            end
            else if (kind < 85)
            begin
                push_request(OP_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            end
            else if (kind < 88)
            begin
                push_request(OP_NOP, 8'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
            end
            else
            begin
                // A line of printable text
                n = $urandom_range(4, 40);
                for (int k = 0; k < n; k++)
                    push_request(OP_PUT, 8'($urandom_range(32, 126)), 8'($urandom),
                                 5'($urandom), 7'($urandom));
            end
            rand_items += n;
        end
        total_items = request_q.size();

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Offer each request until it is taken
        for (int i = 0; i < total_items; i++)
        begin
            if (!quiet_phase(i) && $urandom_range(0, 9) < 3)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= request_q[i].op;
            s_tdata  <= {4'b0, request_q[i].rc, request_q[i].rr,
                         request_q[i].color, request_q[i].ch};
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // Drain outstanding results, then allow for stray ones
        while (expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expect_q.size() != 0)
        begin
            $display("%0d results never arrived", expect_q.size());
            fail_count += expect_q.size();
        end
        $display("Ran %0d requests: %0d reads, %0d clears, %0d scrolls, long output hold-off.",
                 total_items, read_count, clear_count, scroll_count);
        $display("Checked %0d results, %0d failures, %0d cycles.", checked, fail_count,
                 cycle_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/txtcon_pkg.sv
hw/rtl/txtcon_ctrl.sv
hw/rtl/txtcon_dp.sv
hw/rtl/text_console_writer.sv
tb/sv/testbench.sv
